FILE: rtl/core/msr_pkg.sv
// ----------------------------------------------------------------------------
// Minimal standard generator package
// Widths and constants shared by the seed generator core and its arithmetic
// units.
// ----------------------------------------------------------------------------
package msr_pkg;

	// Seed and result width.
	localparam int DATA_W = 31;

	// Multiplier constant width and product width.
	localparam int MULT_W = 15;
	localparam int PROD_W = DATA_W + MULT_W;

	// Counter width for the bit-serial divider (one quotient bit per cycle).
	localparam int DIV_CNT_W = $clog2(DATA_W + 1);

	// Modulus 2^31-1 and the minimal standard multiplier.
	localparam logic [DATA_W-1:0] MOD_P  = 31'h7FFF_FFFF;
	localparam logic [MULT_W-1:0] MULT_A = 15'd16807;

	// Command codes.
	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

endpackage

FILE: rtl/core/msr_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Computes operand * 16807 mod 2^31-1 in two registered steps: a multiply,
// then a fold of the high bits onto the low bits with one final correction.
// ----------------------------------------------------------------------------
module msr_mulmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [msr_pkg::DATA_W-1:0] operand,
	output logic                       done,
	output logic [msr_pkg::DATA_W-1:0] result
);
	import msr_pkg::*;

	logic              v_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              done_q;
	logic [DATA_W-1:0] result_q;
	logic [DATA_W:0]   fold_sum;
	logic [DATA_W-1:0] fold_res;

	// Valid tracking through the two steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= v_s1;
		end
	end

	// Since 2^31 is 1 mod P, the high part folds onto the low part.
	always_comb begin
		fold_sum = {1'b0, prod_s1[DATA_W-1:0]} + (DATA_W+1)'(prod_s1[PROD_W-1:DATA_W]);
		if (fold_sum >= {1'b0, MOD_P}) begin
			fold_res = DATA_W'(fold_sum - {1'b0, MOD_P});
		end else begin
			fold_res = fold_sum[DATA_W-1:0];
		end
	end

	// Product and reduced result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(operand) * PROD_W'(MULT_A);
		end
		if (v_s1) begin
			result_q <= fold_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/core/msr_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division of two 31-bit values, one quotient bit per
// cycle. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module msr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [msr_pkg::DATA_W-1:0] dividend,
	input  logic [msr_pkg::DATA_W-1:0] divisor,
	output logic                       done,
	output logic [msr_pkg::DATA_W-1:0] quotient
);
	import msr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dsr_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W+1:0]    diff;
	logic                 fits;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
		fits  = !diff[DATA_W+1];
	end

	// Control: busy flag, bit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/minimal_standard_rng_draw_core.sv
// ----------------------------------------------------------------------------
// Minimal standard random draw core
// Holds a minimal standard generator seed, loads it on command and draws
// selections.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries command, seed_value and
// range. A load transfer replaces the seed and returns selected = 0 with the
// new seed. A draw transfer advances the seed STEPS_PER_DRAW times by
// seed*16807 mod 2^31-1, then returns 1 + seed / (P / range), or 0 when range
// is zero, together with the new seed.
// Each input transfer yields exactly one output transfer on (out_valid,
// out_stall) carrying selected and new_seed.
// A load goes from the input transfer straight to result delivery, and a draw
// with zero range skips both divisions. Each step runs on the two-stage modular
// multiplier, and each division runs on one shared bit-serial divider that
// produces the 31 quotient bits. One item is in work at a time; in_stall is
// high until the result is placed in the output register, so a new draw is
// not taken before the last one is finished.
// Reset sets the seed to 1 and empties the output register. When the receiver
// stalls, the output register holds its result; a finished item then waits
// until that register is free.
// ----------------------------------------------------------------------------
module minimal_standard_rng_draw_core #(
	parameter int STEPS_PER_DRAW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [msr_pkg::DATA_W-1:0] seed_value,
	input  logic [msr_pkg::DATA_W-1:0] range,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [msr_pkg::DATA_W-1:0] selected,
	output logic [msr_pkg::DATA_W-1:0] new_seed
);
	import msr_pkg::*;

	localparam int CNT_W = $clog2(STEPS_PER_DRAW + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV1,
		ST_DIV2,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] seed_q;
	logic [DATA_W-1:0] range_q;
	logic [DATA_W-1:0] quot_q;
	logic [DATA_W-1:0] sel_q;
	logic              mul_start_q;
	logic              div_start_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_sel_q;
	logic [DATA_W-1:0] out_seed_q;

	logic              mul_done;
	logic [DATA_W-1:0] mul_res;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic [DATA_W-1:0] div_dividend;
	logic [DATA_W-1:0] div_divisor;

	// Shared modular multiplier for the seed steps.
	msr_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.operand (seed_q),
		.done    (mul_done),
		.result  (mul_res)
	);

	// First division gives P / range, the second divides the seed by it.
	assign div_dividend = (state_q == ST_DIV1) ? MOD_P : seed_q;
	assign div_divisor  = (state_q == ST_DIV1) ? range_q : quot_q;

	msr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer, seed register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			seed_q      <= DATA_W'(1);
			range_q     <= '0;
			quot_q      <= '0;
			sel_q       <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_sel_q   <= '0;
			out_seed_q  <= '0;
		end else begin
			// Start pulses: a new draw or another step, then each division.
			mul_start_q <= (state_q == ST_IDLE && in_valid && command == CMD_DRAW) ||
				(state_q == ST_MUL && mul_done && cnt_q != CNT_W'(1));
			div_start_q <= (state_q == ST_MUL && mul_done && cnt_q == CNT_W'(1) &&
				range_q != '0) || (state_q == ST_DIV1 && div_done);

			// Output valid is set when a result is placed and cleared on a transfer.
			if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (command == CMD_LOAD) begin
							seed_q  <= seed_value;
							sel_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							range_q <= range;
							cnt_q   <= CNT_W'(STEPS_PER_DRAW);
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						seed_q <= mul_res;
						if (cnt_q == CNT_W'(1)) begin
							if (range_q == '0) begin
								sel_q   <= '0;
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_DIV1;
							end
						end else begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						quot_q  <= div_quo;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						sel_q   <= div_quo + DATA_W'(1);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_sel_q  <= sel_q;
						out_seed_q <= seed_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign selected  = out_sel_q;
	assign new_seed  = out_seed_q;

`ifndef SYNTHESIS
	// A load transfer goes straight to result delivery.
	a_load_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == CMD_LOAD) |=> state_q == ST_FIN)
		else $error("load did not go to result delivery");

	// The multiplier only completes while the sequencer waits for it.
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL)
		else $error("multiplier completed outside the step phase");

	// The divider only completes during one of the two divisions.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider completed outside a division phase");

	// Leaving result delivery always fills the output register.
	a_fin_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && (!out_valid_q || !out_stall)) |=> out_valid_q)
		else $error("result not placed in the output register");
`endif

endmodule
